// File: rtl/shuffled_lehmer_random_generator_macros.svh
// Assertion macros for the shuffled Lehmer random generator.
`ifndef SHUFFLED_LEHMER_RANDOM_GENERATOR_MACROS_SVH
`define SHUFFLED_LEHMER_RANDOM_GENERATOR_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SLRG_ASSERT_NOW(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("slrg assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define SLRG_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("slrg assertion failed");

`endif

// File: rtl/slrg_pkg.sv
// Shared constants for the shuffled Lehmer random generator.
package slrg_pkg;

    localparam int VALUE_W   = 31;
    localparam int MULT_W    = 15;
    localparam int PRODUCT_W = VALUE_W + MULT_W;

    localparam logic [VALUE_W-1:0] MODULUS    = 31'h7FFF_FFFF;
    localparam logic [MULT_W-1:0]  MULTIPLIER = 15'd16807;

    localparam int DEFAULT_TABLE_ENTRIES = 32;
    localparam int DEFAULT_WARMUP_STEPS  = 8;

endpackage

// File: rtl/slrg_step.sv
// Lehmer step unit: registered multiply by 16807, then fold modulo 2^31-1.
module slrg_step (
    input  logic                         aclk,
    input  logic                         load,
    input  logic [slrg_pkg::VALUE_W-1:0] operand,
    output logic [slrg_pkg::VALUE_W-1:0] result
);
    import slrg_pkg::*;

    logic [PRODUCT_W-1:0] product_reg;
    logic [VALUE_W:0]     fold_sum;

    always_ff @(posedge aclk) begin
        if (load) begin
            product_reg <= PRODUCT_W'(operand) * PRODUCT_W'(MULTIPLIER);
        end
    end

    assign fold_sum = {1'b0, product_reg[VALUE_W-1:0]}
                    + (VALUE_W+1)'(product_reg[PRODUCT_W-1:VALUE_W]);

    assign result = (fold_sum >= {1'b0, MODULUS})
                  ? VALUE_W'(fold_sum - {1'b0, MODULUS})
                  : fold_sum[VALUE_W-1:0];

endmodule

// File: rtl/shuffled_lehmer_random_generator.sv
// Top level of the shuffled Lehmer random generator.
// Park-Miller generator (x * 16807 mod 2^31-1) behind a Bays-Durham shuffle table. Each
// request with draw_request high returns one value in 1 to 2^31-2; divide by 2^31 for a
// uniform fraction. When TABLE_ENTRIES is a power of two, a draw is a table read plus one
// pass through the multiply-and-fold step unit; otherwise the slot division first adds
// clog2(TABLE_ENTRIES) compare-subtract steps and a separate table read state. A result
// still held on the output stalls the draw in its final state until m_ready. The first draw
// after reset or after a seed write first seeds the table through the same step unit,
// discarding the first WARMUP_STEPS values and writing the next TABLE_ENTRIES into the
// table, and then takes the separate table read state also when TABLE_ENTRIES is a power
// of two. A request with draw_request low is dropped with no result. Write the seed only
// while idle.
`include "shuffled_lehmer_random_generator_macros.svh"

module shuffled_lehmer_random_generator #(
    parameter int TABLE_ENTRIES = slrg_pkg::DEFAULT_TABLE_ENTRIES,
    parameter int WARMUP_STEPS  = slrg_pkg::DEFAULT_WARMUP_STEPS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [slrg_pkg::VALUE_W-1:0] cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_draw_request,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [slrg_pkg::VALUE_W-1:0] m_random_value
);
    import slrg_pkg::*;

    localparam int IDX_W       = $clog2(TABLE_ENTRIES);
    localparam bit SLOT_POW2   = ((1 << IDX_W) == TABLE_ENTRIES);
    localparam int TOTAL_STEPS = WARMUP_STEPS + TABLE_ENTRIES;
    localparam int CNT_W       = $clog2(TOTAL_STEPS);
    localparam int BIT_W       = (IDX_W > 1) ? $clog2(IDX_W) : 1;
    localparam int DIV_W       = VALUE_W + IDX_W;
    localparam logic [VALUE_W-1:0] SLOT_DIVISOR =
        VALUE_W'(32'd1 + (32'(MODULUS) - 32'd1) / 32'(TABLE_ENTRIES));

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_SEED_MUL  = 3'd1;
    localparam logic [2:0] S_SEED_FOLD = 3'd2;
    localparam logic [2:0] S_DIV       = 3'd3;
    localparam logic [2:0] S_DRAW_READ = 3'd4;
    localparam logic [2:0] S_DRAW_DONE = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [BIT_W-1:0]   div_bit_reg, div_bit_next;
    logic [VALUE_W-1:0] rem_reg, rem_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [VALUE_W-1:0] gen_reg, gen_next;
    logic [VALUE_W-1:0] last_reg, last_next;
    logic [VALUE_W-1:0] seed_reg, seed_next;
    logic               seeded_reg, seeded_next;
    logic               m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0] m_value_reg, m_value_next;
    logic [VALUE_W-1:0] rd_data_reg;

    logic [VALUE_W-1:0] shuffle_mem [TABLE_ENTRIES];

    logic               accept;
    logic               out_free;
    logic               go_draw;
    logic               step_load;
    logic               rd_en;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    logic [VALUE_W-1:0] step_value;
    logic [VALUE_W-1:0] start_seed;
    logic               seed_write;
    logic [IDX_W-1:0]   seed_idx;
    logic [IDX_W-1:0]   slot_raw;
    logic [IDX_W-1:0]   slot_eff;
    logic [DIV_W-1:0]   div_trial;
    logic [DIV_W-1:0]   rem_ext;
    logic               div_ge;

    slrg_step u_step (
        .aclk    (aclk),
        .load    (step_load),
        .operand (gen_reg),
        .result  (step_value)
    );

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    assign start_seed = (seed_reg == MODULUS || seed_reg == '0) ? VALUE_W'(1) : seed_reg;
    assign seed_write = (cnt_reg >= CNT_W'(WARMUP_STEPS));
    assign seed_idx   = IDX_W'(cnt_reg - CNT_W'(WARMUP_STEPS));

    assign slot_raw = SLOT_POW2 ? last_reg[VALUE_W-1 -: IDX_W] : slot_reg;
    assign slot_eff = ({1'b0, slot_raw} >= (IDX_W+1)'(TABLE_ENTRIES))
                    ? IDX_W'(TABLE_ENTRIES - 1) : slot_raw;

    assign div_trial = DIV_W'(SLOT_DIVISOR) << div_bit_reg;
    assign rem_ext   = DIV_W'(rem_reg);
    assign div_ge    = (rem_ext >= div_trial);

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        div_bit_next = div_bit_reg;
        rem_next     = rem_reg;
        slot_next    = slot_reg;
        gen_next     = gen_reg;
        last_next    = last_reg;
        seed_next    = seed_reg;
        seeded_next  = seeded_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_value_next = m_value_reg;
        go_draw      = 1'b0;
        step_load    = 1'b0;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        wr_idx       = slot_eff;

        case (state_reg)
            S_IDLE: begin
                if (accept && s_draw_request) begin
                    if (!seeded_reg) begin
                        gen_next   = start_seed;
                        cnt_next   = '0;
                        state_next = S_SEED_MUL;
                    end else begin
                        go_draw = 1'b1;
                    end
                end
            end
            S_SEED_MUL: begin
                step_load  = 1'b1;
                state_next = S_SEED_FOLD;
            end
            S_SEED_FOLD: begin
                gen_next = step_value;
                if (seed_write) begin
                    wr_en  = 1'b1;
                    wr_idx = seed_idx;
                    if (seed_idx == '0) begin
                        last_next = step_value;
                    end
                end
                if (cnt_reg == CNT_W'(TOTAL_STEPS - 1)) begin
                    seeded_next = 1'b1;
                    go_draw     = 1'b1;
                end else begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = S_SEED_MUL;
                end
            end
            S_DIV: begin
                if (div_ge) begin
                    rem_next              = VALUE_W'(rem_ext - div_trial);
                    slot_next[div_bit_reg] = 1'b1;
                end
                if (div_bit_reg == '0) begin
                    state_next = S_DRAW_READ;
                end else begin
                    div_bit_next = div_bit_reg - BIT_W'(1);
                end
            end
            S_DRAW_READ: begin
                step_load  = 1'b1;
                rd_en      = 1'b1;
                state_next = S_DRAW_DONE;
            end
            S_DRAW_DONE: begin
                if (out_free) begin
                    gen_next     = step_value;
                    wr_en        = 1'b1;
                    last_next    = rd_data_reg;
                    m_valid_next = 1'b1;
                    m_value_next = rd_data_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (go_draw) begin
            if (!SLOT_POW2) begin
                rem_next     = last_reg;
                slot_next    = '0;
                div_bit_next = BIT_W'(IDX_W - 1);
                state_next   = S_DIV;
            end else if (state_reg == S_IDLE) begin
                step_load  = 1'b1;
                rd_en      = 1'b1;
                state_next = S_DRAW_DONE;
            end else begin
                state_next = S_DRAW_READ;
            end
        end

        if (cfg_wr_en) begin
            seed_next   = cfg_wr_data;
            seeded_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            div_bit_reg <= '0;
            seed_reg    <= VALUE_W'(1);
            seeded_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            div_bit_reg <= div_bit_next;
            seed_reg    <= seed_next;
            seeded_reg  <= seeded_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg     <= rem_next;
        slot_reg    <= slot_next;
        gen_reg     <= gen_next;
        last_reg    <= last_next;
        m_value_reg <= m_value_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            shuffle_mem[wr_idx] <= step_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= shuffle_mem[slot_eff];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_random_value = m_value_reg;

    `SLRG_ASSERT_NEXT(a_done_loads_result, aclk, aresetn,
        state_reg == S_DRAW_DONE && out_free, m_valid && state_reg == S_IDLE)
    `SLRG_ASSERT_NEXT(a_seeding_sets_flag, aclk, aresetn,
        state_reg == S_SEED_FOLD && cnt_reg == CNT_W'(TOTAL_STEPS - 1) && !cfg_wr_en,
        seeded_reg)
    `SLRG_ASSERT_NOW(a_result_in_range, aclk, aresetn,
        m_valid, m_random_value != '0 && m_random_value != MODULUS)
    `SLRG_ASSERT_NOW(a_generator_in_range, aclk, aresetn,
        seeded_reg, gen_reg != '0 && gen_reg != MODULUS)

endmodule
